// ===== sv/tsrb_pkg.sv =====
package tsrb_pkg;

    // Capacity and precision of the block.
    localparam int MAX_ROWS   = 4096;
    localparam int ALPHA_BITS = 16;

    // Field widths.
    localparam int ROW_W      = 12;
    localparam int PIX_W      = 8;
    localparam int DECAY_W    = 7;
    localparam int CHANNELS   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY        = 2'd2;

    // The tanh argument is an unsigned Q.8 value.
    localparam int FRAC_BITS   = 8;
    localparam int NUM_W       = ROW_W + FRAC_BITS;
    localparam int DECAY_CODES = 1 << DECAY_W;

    // Exact quotient by multiplication with a rounded-up reciprocal.
    localparam int RECIP_SHIFT = NUM_W + DECAY_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // tanh(k/8) for k = 0..32 in Q0.16, interpolated over 32 steps.
    localparam int TANH_ENTRIES = 33;
    localparam int TANH_IDX_W   = 6;
    localparam int TANH_SEG_W   = 5;
    localparam int TANH_STEP_W  = 5;
    localparam int TANH_W       = 17;
    localparam logic [TANH_W-1:0] TANH_ONE = 17'h10000;

    localparam logic [TANH_W-1:0] TANH_Q16 [TANH_ENTRIES] = '{
        17'd0,     17'd8150,  17'd16051, 17'd23485, 17'd30285, 17'd36346,
        17'd41625, 17'd46131, 17'd49912, 17'd53038, 17'd55593, 17'd57660,
        17'd59320, 17'd60643, 17'd61694, 17'd62524, 17'd63179, 17'd63693,
        17'd64096, 17'd64412, 17'd64659, 17'd64852, 17'd65003, 17'd65120,
        17'd65212, 17'd65283, 17'd65339, 17'd65383, 17'd65417, 17'd65443,
        17'd65464, 17'd65480, 17'd65492
    };

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    typedef struct packed {
        logic [ROW_W-1:0]   focus_top;
        logic [ROW_W-1:0]   focus_bottom;
        logic [DECAY_W-1:0] decay;
    } cfg_t;

    typedef struct packed {
        logic [CHANNELS-1:0][PIX_W-1:0] sharp;
        logic [CHANNELS-1:0][PIX_W-1:0] blurred;
    } pixel_t;

    // Rounded numerator of |row - reference| / divisor, with the sign kept apart.
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] num;
    } ref_num_t;

    typedef struct packed {
        ref_num_t           top;
        ref_num_t           bottom;
        logic [RECIP_W-1:0] recip;
        pixel_t             pix;
    } work_t;

    typedef struct packed {
        logic                   neg;
        logic                   sat;
        logic [TANH_SEG_W-1:0]  seg;
        logic [TANH_STEP_W-1:0] step;
    } tanh_arg_t;

endpackage

// ===== sv/tsrb_front.sv =====
module tsrb_front (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic [tsrb_pkg::ROW_W-1:0]                  row_index,
    input  logic [tsrb_pkg::CHANNELS-1:0][tsrb_pkg::PIX_W-1:0] sharp,
    input  logic [tsrb_pkg::CHANNELS-1:0][tsrb_pkg::PIX_W-1:0] blurred,
    input  tsrb_pkg::cfg_t                              cfg,
    output logic                                        push_valid,
    input  logic                                        push_ready,
    output tsrb_pkg::work_t                             push_item
);

    logic                              f_valid_reg;
    logic                              f_valid_next;
    tsrb_pkg::work_t                   f_item_reg;
    tsrb_pkg::work_t                   f_item_next;
    logic                              advance;
    logic [tsrb_pkg::ROW_W-1:0]        row_clamped;
    logic [tsrb_pkg::DECAY_W:0]        divisor;
    logic [tsrb_pkg::DECAY_W-1:0]      half_divisor;
    logic [tsrb_pkg::RECIP_W-1:0]      recip_tab [tsrb_pkg::DECAY_CODES];

    // ceil(2^RECIP_SHIFT / (d + 1)) for every decay code, fixed at elaboration.
    for (genvar d = 0; d < tsrb_pkg::DECAY_CODES; d++)
    begin : g_recip
        localparam logic [tsrb_pkg::RECIP_W-1:0] RECIP =
            tsrb_pkg::RECIP_W'(((64'd1 << tsrb_pkg::RECIP_SHIFT) + d) / (d + 1));
        assign recip_tab[d] = RECIP;
    end

    function automatic logic [tsrb_pkg::ROW_W-1:0] clamp_row(
        input logic [tsrb_pkg::ROW_W-1:0] r
    );
        if (32'(r) > tsrb_pkg::MAX_ROWS - 1)
        begin
            return tsrb_pkg::ROW_W'(tsrb_pkg::MAX_ROWS - 1);
        end
        return r;
    endfunction

    function automatic tsrb_pkg::ref_num_t ref_numerator(
        input logic [tsrb_pkg::ROW_W-1:0]   row,
        input logic [tsrb_pkg::ROW_W-1:0]   ref_row,
        input logic [tsrb_pkg::DECAY_W-1:0] half
    );
        tsrb_pkg::ref_num_t         res;
        logic [tsrb_pkg::ROW_W-1:0] mag;
        res.neg = row < ref_row;
        mag     = res.neg ? (ref_row - row) : (row - ref_row);
        res.num = {mag, tsrb_pkg::FRAC_BITS'(0)} + tsrb_pkg::NUM_W'(half);
        return res;
    endfunction

    assign advance    = !f_valid_reg || push_ready;
    assign in_stall   = !advance;
    assign push_valid = f_valid_reg;
    assign push_item  = f_item_reg;

    always_comb
    begin
        divisor               = {1'b0, cfg.decay} + 1'b1;
        half_divisor          = divisor[tsrb_pkg::DECAY_W:1];
        row_clamped           = clamp_row(row_index);
        f_item_next.top       = ref_numerator(row_clamped, clamp_row(cfg.focus_top),
                                              half_divisor);
        f_item_next.bottom    = ref_numerator(row_clamped, clamp_row(cfg.focus_bottom),
                                              half_divisor);
        f_item_next.recip     = recip_tab[cfg.decay];
        f_item_next.pix.sharp   = sharp;
        f_item_next.pix.blurred = blurred;
        f_valid_next          = advance ? in_valid : f_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

// ===== sv/tsrb_queue.sv =====
module tsrb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  tsrb_pkg::work_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tsrb_pkg::work_t pop_item
);

    tsrb_pkg::work_t                   mem_reg [tsrb_pkg::QUEUE_DEPTH];
    logic [tsrb_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [tsrb_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [tsrb_pkg::QUEUE_PTR_W:0]    count_reg;
    logic [tsrb_pkg::QUEUE_PTR_W:0]    count_next;
    logic                              push;
    logic                              pop;

    assign push_ready = count_reg != (tsrb_pkg::QUEUE_PTR_W + 1)'(tsrb_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/tsrb_back.sv =====
module tsrb_back (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               pop_valid,
    output logic                                               pop_ready,
    input  tsrb_pkg::work_t                                    pop_item,
    output logic                                               out_valid,
    input  logic                                               out_stall,
    output logic [tsrb_pkg::CHANNELS-1:0][tsrb_pkg::PIX_W-1:0] out_pix
);

    localparam int AB    = tsrb_pkg::ALPHA_BITS;
    localparam int SEG   = tsrb_pkg::TANH_SEG_W;
    localparam int STEP  = tsrb_pkg::TANH_STEP_W;
    localparam int TW    = tsrb_pkg::TANH_W;
    localparam int SUM_W = AB + tsrb_pkg::PIX_W + 1;

    logic                                               advance;
    logic                                               s1_valid_reg;
    logic                                               s2_valid_reg;
    logic                                               s3_valid_reg;
    logic                                               out_valid_reg;
    tsrb_pkg::tanh_arg_t                                s1_top_reg;
    tsrb_pkg::tanh_arg_t                                s1_bot_reg;
    tsrb_pkg::pixel_t                                   s1_pix_reg;
    logic signed [TW:0]                                 s2_top_reg;
    logic signed [TW:0]                                 s2_bot_reg;
    tsrb_pkg::pixel_t                                   s2_pix_reg;
    logic [AB-1:0]                                      s3_alpha_reg;
    logic [AB-1:0]                                      s3_alpha_next;
    tsrb_pkg::pixel_t                                   s3_pix_reg;
    logic [tsrb_pkg::CHANNELS-1:0][tsrb_pkg::PIX_W-1:0] out_pix_reg;
    logic [tsrb_pkg::CHANNELS-1:0][tsrb_pkg::PIX_W-1:0] out_pix_next;
    logic signed [TW+1:0]                               diff;
    logic [TW+AB:0]                                     scaled;
    logic [AB:0]                                        alpha_round;
    logic [AB:0]                                        one_minus;
    logic [SUM_W-1:0]                                   sum;
    logic [tsrb_pkg::PIX_W:0]                           blended;

    // Quotient x of the tanh argument in Q.8; x of 4.0 or more saturates.
    function automatic tsrb_pkg::tanh_arg_t make_arg(
        input tsrb_pkg::ref_num_t           n,
        input logic [tsrb_pkg::RECIP_W-1:0] r
    );
        logic [tsrb_pkg::PROD_W-1:0] prod;
        tsrb_pkg::tanh_arg_t         a;
        prod   = tsrb_pkg::PROD_W'(n.num) * tsrb_pkg::PROD_W'(r);
        a.neg  = n.neg;
        a.sat  = |prod[tsrb_pkg::PROD_W-1:tsrb_pkg::RECIP_SHIFT+SEG+STEP];
        a.seg  = prod[tsrb_pkg::RECIP_SHIFT+SEG+STEP-1 -: SEG];
        a.step = prod[tsrb_pkg::RECIP_SHIFT+STEP-1 -: STEP];
        return a;
    endfunction

    function automatic logic signed [TW:0] tanh_value(input tsrb_pkg::tanh_arg_t a);
        logic [tsrb_pkg::TANH_IDX_W-1:0] lo_idx;
        logic [tsrb_pkg::TANH_IDX_W-1:0] hi_idx;
        logic [TW-1:0]                   lo;
        logic [TW-1:0]                   hi;
        logic [TW+STEP-1:0]              span;
        logic [TW-1:0]                   mag;
        logic signed [TW:0]              res;
        lo_idx = tsrb_pkg::TANH_IDX_W'(a.seg);
        hi_idx = lo_idx + 1'b1;
        lo     = tsrb_pkg::TANH_Q16[lo_idx];
        hi     = tsrb_pkg::TANH_Q16[hi_idx];
        span   = (TW + STEP)'(hi - lo) * (TW + STEP)'(a.step)
               + ((TW + STEP)'(1) << (STEP - 1));
        mag    = a.sat ? tsrb_pkg::TANH_ONE : lo + TW'(span >> STEP);
        res    = $signed({1'b0, mag});
        return a.neg ? -res : res;
    endfunction

    // The whole back pipeline moves together whenever the output register can take a result.
    assign advance   = !out_valid_reg || !out_stall;
    assign pop_ready = advance;
    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;

    always_comb
    begin
        diff        = (TW + 2)'(s2_top_reg) - (TW + 2)'(s2_bot_reg);
        scaled      = ((TW + AB + 1)'(diff[TW:0]) << AB) + (TW + AB + 1)'(tsrb_pkg::TANH_ONE);
        alpha_round = scaled[TW+AB:TW];
        if (diff <= 0)
        begin
            s3_alpha_next = '0;
        end
        else if (alpha_round[AB])
        begin
            s3_alpha_next = '1;
        end
        else
        begin
            s3_alpha_next = alpha_round[AB-1:0];
        end
    end

    always_comb
    begin
        one_minus    = (AB + 1)'(1) << AB;
        one_minus    = one_minus - (AB + 1)'(s3_alpha_reg);
        sum          = '0;
        blended      = '0;
        out_pix_next = '0;
        for (int c = 0; c < tsrb_pkg::CHANNELS; c++)
        begin
            sum = SUM_W'(s3_alpha_reg) * SUM_W'(s3_pix_reg.sharp[c])
                + SUM_W'(one_minus) * SUM_W'(s3_pix_reg.blurred[c])
                + (SUM_W'(1) << (AB - 1));
            blended = sum[SUM_W-1:AB];
            out_pix_next[c] = blended[tsrb_pkg::PIX_W] ? '1 : blended[tsrb_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_top_reg   <= make_arg(pop_item.top, pop_item.recip);
            s1_bot_reg   <= make_arg(pop_item.bottom, pop_item.recip);
            s1_pix_reg   <= pop_item.pix;
            s2_top_reg   <= tanh_value(s1_top_reg);
            s2_bot_reg   <= tanh_value(s1_bot_reg);
            s2_pix_reg   <= s1_pix_reg;
            s3_alpha_reg <= s3_alpha_next;
            s3_pix_reg   <= s2_pix_reg;
            out_pix_reg  <= out_pix_next;
        end
    end

endmodule

// ===== sv/tilt_shift_row_blend_top.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    row_index, sharp_*, blurred_*
// output    out        out_valid / out_stall  out_blue, out_green, out_red
// config    in         cfg_write_en           cfg_index, cfg_data
//
// One pixel is taken per clock while in_stall is low. The back pipeline registers the
// results of its two reciprocal multipliers, tanh interpolation, alpha and blend
// stages in turn.
// Reset clears the valid flags and the queue and loads the focus rows 1024 and 3072 and decay 0.
// A stalled output holds the back pipeline; the four-entry queue and the front register
// then fill before in_stall is raised.
module tilt_shift_row_blend_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tsrb_pkg::ROW_W-1:0]         row_index,
    input  logic [tsrb_pkg::PIX_W-1:0]         sharp_blue,
    input  logic [tsrb_pkg::PIX_W-1:0]         sharp_green,
    input  logic [tsrb_pkg::PIX_W-1:0]         sharp_red,
    input  logic [tsrb_pkg::PIX_W-1:0]         blurred_blue,
    input  logic [tsrb_pkg::PIX_W-1:0]         blurred_green,
    input  logic [tsrb_pkg::PIX_W-1:0]         blurred_red,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tsrb_pkg::PIX_W-1:0]         out_blue,
    output logic [tsrb_pkg::PIX_W-1:0]         out_green,
    output logic [tsrb_pkg::PIX_W-1:0]         out_red,
    input  logic                               cfg_write_en,
    input  logic [tsrb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsrb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tsrb_pkg::cfg_t                                     cfg_reg;
    tsrb_pkg::cfg_t                                     cfg_next;
    logic                                               push_valid;
    logic                                               push_ready;
    tsrb_pkg::work_t                                    push_item;
    logic                                               pop_valid;
    logic                                               pop_ready;
    tsrb_pkg::work_t                                    pop_item;
    logic [tsrb_pkg::CHANNELS-1:0][tsrb_pkg::PIX_W-1:0] out_pix;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                tsrb_pkg::CFG_FOCUS_TOP:    cfg_next.focus_top    = cfg_data;
                tsrb_pkg::CFG_FOCUS_BOTTOM: cfg_next.focus_bottom = cfg_data;
                tsrb_pkg::CFG_DECAY:        cfg_next.decay = cfg_data[tsrb_pkg::DECAY_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focus_top    <= tsrb_pkg::ROW_W'(1024);
            cfg_reg.focus_bottom <= tsrb_pkg::ROW_W'(3072);
            cfg_reg.decay        <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tsrb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .row_index  (row_index),
        .sharp      ({sharp_red, sharp_green, sharp_blue}),
        .blurred    ({blurred_red, blurred_green, blurred_blue}),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    tsrb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    tsrb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pix   (out_pix)
    );

    assign out_blue  = out_pix[0];
    assign out_green = out_pix[1];
    assign out_red   = out_pix[2];

endmodule
